### hdl/smx_pkg.sv
// Shared types, constants and the exponent table for the softmax core.
// Used by smx_front, smx_div, smx_back and softmax_vector_with_slope_core.
package smx_pkg;

	localparam int SMX_MAX_LEN  = 64;
	localparam int OQ_DEPTH     = 8;
	localparam int OQ_AW        = 3;
	localparam int RECIP_SHIFT  = 40;
	localparam int NUM_W        = RECIP_SHIFT + 1;
	localparam int RECIP_W      = 25;
	localparam int ADDR_W       = 2;
	localparam logic [ADDR_W-1:0] REG_SLOPE_MODE = 2'd0;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [16:0] ONE_Q16   = 17'h10000;

	typedef struct packed {
		logic signed [15:0] score;
		logic               last_element;
	} in_item_t;

	typedef struct packed {
		logic [15:0] prob;
		logic        last_result;
	} out_item_t;

	// Back part status seen by the front part
	typedef struct packed {
		logic take;
		logic scan_busy;
	} bk_status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_SCAN,
		BK_DRAIN,
		BK_DIV,
		BK_EMIT
	} back_state_t;

	// 2^(-k/16) in Q16, k = 0..16
	function automatic logic [16:0] exp2_tab(input logic [4:0] k);
		logic [16:0] v;
		unique case (k)
			5'd0:    v = 17'd65536;
			5'd1:    v = 17'd62757;
			5'd2:    v = 17'd60097;
			5'd3:    v = 17'd57549;
			5'd4:    v = 17'd55109;
			5'd5:    v = 17'd52773;
			5'd6:    v = 17'd50535;
			5'd7:    v = 17'd48393;
			5'd8:    v = 17'd46341;
			5'd9:    v = 17'd44376;
			5'd10:   v = 17'd42495;
			5'd11:   v = 17'd40693;
			5'd12:   v = 17'd38968;
			5'd13:   v = 17'd37316;
			5'd14:   v = 17'd35734;
			5'd15:   v = 17'd34219;
			5'd16:   v = 17'd32768;
			default: v = 17'd32768;
		endcase
		return v;
	endfunction

endpackage

### hdl/smx_front.sv
// Front part: accepts score items, fills the score store, tracks count and maximum.
// Hands a finished vector to the back part through a one-entry job register. Uses smx_pkg.
module smx_front import smx_pkg::*; #(
	parameter int MAX_LEN = SMX_MAX_LEN,
	localparam int AW = $clog2(MAX_LEN),
	localparam int CW = $clog2(MAX_LEN + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  in_item_t            item,
	input  bk_status_t          status,
	input  logic [AW-1:0]       rd_addr,
	output logic signed [15:0]  rd_score,
	output logic                job_valid,
	output logic [CW-1:0]       job_count,
	output logic signed [15:0]  job_max
);

	logic [CW-1:0]       count_q;
	logic signed [15:0]  max_q;
	logic                job_valid_q;
	logic [CW-1:0]       job_count_q;
	logic signed [15:0]  job_max_q;
	logic signed [15:0]  store_q [MAX_LEN];
	logic                accept;
	logic                store_en;
	logic [CW-1:0]       count_nx;
	logic signed [15:0]  max_nx;

	// Hold off input while a job waits or the back part still reads the store
	assign full     = job_valid_q || status.scan_busy;
	assign accept   = push && !full;
	assign store_en = accept && (count_q < CW'(MAX_LEN));
	assign count_nx = store_en ? count_q + CW'(1) : count_q;
	assign max_nx   = (store_en && (item.score > max_q)) ? item.score : max_q;

	// Advance count and maximum, close the vector on the last element
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			max_q       <= 16'sh8000;
			job_valid_q <= 1'b0;
		end else begin
			if (accept && item.last_element) begin
				job_valid_q <= 1'b1;
				count_q     <= '0;
				max_q       <= 16'sh8000;
			end else begin
				if (status.take)
					job_valid_q <= 1'b0;
				count_q <= count_nx;
				max_q   <= max_nx;
			end
		end
	end

	// Job payload
	always_ff @(posedge clk) begin
		if (accept && item.last_element) begin
			job_count_q <= count_nx;
			job_max_q   <= max_nx;
		end
	end

	// Score store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (store_en)
			store_q[count_q[AW-1:0]] <= item.score;
		rd_score <= store_q[rd_addr];
	end

	assign job_valid = job_valid_q;
	assign job_count = job_count_q;
	assign job_max   = job_max_q;

endmodule

### hdl/smx_div.sv
// Restoring divider for the reciprocal (2^40 + d/2) / d, one quotient bit a cycle.
// Uses smx_pkg for the numerator and quotient widths.
module smx_div import smx_pkg::*; #(
	parameter int DEN_W = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [DEN_W-1:0]   den,
	output logic               done,
	output logic [RECIP_W-1:0] quot
);

	logic [NUM_W-1:0]   num_q;
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W-1:0]   rem_q;
	logic [RECIP_W-1:0] quot_q;
	logic [5:0]         step_q;
	logic               busy_q;
	logic               done_q;
	logic [DEN_W:0]     trial;
	logic               ge;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				step_q <= 6'(NUM_W);
			end else if (busy_q) begin
				step_q <= step_q - 6'd1;
				if (step_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift in one numerator bit, subtract where it fits
	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			num_q  <= (NUM_W'(1) << RECIP_SHIFT) + NUM_W'(den >> 1);
			den_q  <= den;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			num_q  <= num_q << 1;
			rem_q  <= ge ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
			quot_q <= {quot_q[RECIP_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

### hdl/smx_back.sv
// Back part: exponent scan with running sum, reciprocal, then scaling and result queue.
// Uses smx_pkg and smx_div; reads the score store held in smx_front.
module smx_back import smx_pkg::*; #(
	parameter int MAX_LEN = SMX_MAX_LEN,
	localparam int AW = $clog2(MAX_LEN),
	localparam int CW = $clog2(MAX_LEN + 1),
	localparam int SW = CW + 17
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               slope_mode,
	input  logic               job_valid,
	input  logic [CW-1:0]      job_count,
	input  logic signed [15:0] job_max,
	output bk_status_t         status,
	output logic [AW-1:0]      rd_addr,
	input  logic signed [15:0] rd_score,
	output logic               empty,
	input  logic               pop,
	output out_item_t          result
);

	back_state_t        state_q, state_nx;
	logic [CW-1:0]      cnt_q;
	logic signed [15:0] max_q;
	logic [AW-1:0]      idx_q;
	logic               idx_last;
	logic               take, sc_issue, em_issue, div_start;
	logic [SW-1:0]      sum_q;
	logic [RECIP_W-1:0] recip_q, div_quot;
	logic               div_done;
	logic [16:0]        exp_q [MAX_LEN];

	// Scan pipeline
	logic               sc_v_s1, sc_v_s2, sc_v_s3;
	logic [AW-1:0]      sc_a_s1, sc_a_s2, sc_a_s3;
	logic [15:0]        sc_u;
	logic [32:0]        sc_p_s2;
	logic [4:0]         sc_n;
	logic [3:0]         sc_i;
	logic [11:0]        sc_r;
	logic [16:0]        sc_hi, sc_lo;
	logic [23:0]        sc_dr_s3;
	logic [16:0]        sc_hi_s3;
	logic [4:0]         sc_n_s3;
	logic [16:0]        sc_m;
	logic [24:0]        sc_rnd;
	logic [16:0]        sc_e;

	// Emit pipeline
	logic               em_v_s1, em_v_s2, em_v_s3;
	logic               em_l_s1, em_l_s2, em_l_s3;
	logic [16:0]        em_e_s1;
	logic [41:0]        em_p_s2;
	logic [17:0]        em_sr;
	logic [16:0]        em_s;
	logic [16:0]        em_s_s3;
	logic [33:0]        em_sq_s3;
	logic [16:0]        em_v;
	out_item_t          em_out;
	logic [2:0]         inflight;

	// Result queue
	out_item_t          oq_q [OQ_DEPTH];
	logic [OQ_AW-1:0]   oq_wr_q, oq_rd_q;
	logic [OQ_AW:0]     oq_cnt_q;
	logic               oq_push, oq_pop;

	assign idx_last = (CW'(idx_q) + CW'(1)) == cnt_q;
	assign inflight = 3'(em_v_s1) + 3'(em_v_s2) + 3'(em_v_s3);

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			BK_IDLE:  if (job_valid) state_nx = BK_SCAN;
			BK_SCAN:  if (idx_last) state_nx = BK_DRAIN;
			BK_DRAIN: if (!sc_v_s1 && !sc_v_s2 && !sc_v_s3) state_nx = BK_DIV;
			BK_DIV:   if (div_done) state_nx = BK_EMIT;
			BK_EMIT:  if (em_issue && idx_last) state_nx = BK_IDLE;
			default:  state_nx = BK_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		take      = 1'b0;
		sc_issue  = 1'b0;
		em_issue  = 1'b0;
		div_start = 1'b0;
		unique case (state_q)
			BK_IDLE:  take = job_valid;
			BK_SCAN:  sc_issue = 1'b1;
			BK_DRAIN: div_start = !sc_v_s1 && !sc_v_s2 && !sc_v_s3;
			BK_DIV:   ;
			BK_EMIT:  em_issue = ({1'b0, oq_cnt_q} + (OQ_AW + 2)'(inflight)) < OQ_DEPTH;
			default:  ;
		endcase
	end

	assign status.take      = take;
	assign status.scan_busy = (state_q == BK_SCAN) || (state_q == BK_DRAIN);
	assign rd_addr          = idx_q;

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			idx_q   <= '0;
			sc_v_s1 <= 1'b0;
			sc_v_s2 <= 1'b0;
			sc_v_s3 <= 1'b0;
			em_v_s1 <= 1'b0;
			em_v_s2 <= 1'b0;
			em_v_s3 <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (sc_issue || em_issue)
				idx_q <= idx_last ? '0 : idx_q + AW'(1);
			sc_v_s1 <= sc_issue;
			sc_v_s2 <= sc_v_s1;
			sc_v_s3 <= sc_v_s2;
			em_v_s1 <= em_issue;
			em_v_s2 <= em_v_s1;
			em_v_s3 <= em_v_s2;
		end
	end

	// Latch the job and reset the running sum
	always_ff @(posedge clk) begin
		if (take) begin
			cnt_q <= job_count;
			max_q <= job_max;
			sum_q <= '0;
		end else if (sc_v_s3) begin
			sum_q <= sum_q + SW'(sc_e);
		end
		if (div_done)
			recip_q <= div_quot;
	end

	// Scan stage 1: distance below the maximum, times log2(e)
	assign sc_u = 16'(max_q - rd_score);

	// Scan stage 2: table lookup and interpolation product
	assign sc_n  = sc_p_s2[32:28];
	assign sc_i  = sc_p_s2[27:24];
	assign sc_r  = sc_p_s2[23:12];
	assign sc_hi = exp2_tab({1'b0, sc_i});
	assign sc_lo = exp2_tab(5'({1'b0, sc_i}) + 5'd1);

	// Scan stage 3: interpolate, then rounding shift by the integer exponent
	assign sc_m   = sc_hi_s3 - 17'((sc_dr_s3 + 24'd2048) >> 12);
	assign sc_rnd = (25'd1 << sc_n_s3) >> 1;
	assign sc_e   = 17'((25'(sc_m) + sc_rnd) >> sc_n_s3);

	always_ff @(posedge clk) begin
		sc_a_s1  <= idx_q;
		sc_a_s2  <= sc_a_s1;
		sc_a_s3  <= sc_a_s2;
		sc_p_s2  <= 33'(sc_u) * 33'(LOG2E_Q16);
		sc_dr_s3 <= 24'(sc_hi - sc_lo) * 24'(sc_r);
		sc_hi_s3 <= sc_hi;
		sc_n_s3  <= sc_n;
	end

	// Exponent store: written by the scan, read by the emit
	always_ff @(posedge clk) begin
		if (sc_v_s3)
			exp_q[sc_a_s3] <= sc_e;
		em_e_s1 <= exp_q[idx_q];
	end

	smx_div #(.DEN_W(SW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.den    (sum_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	// Emit stage 2: round the scaled value, clamp, form s*(1-s)
	assign em_sr = 18'((em_p_s2 + (42'd1 << 23)) >> 24);
	assign em_s  = (em_sr > 18'(ONE_Q16)) ? ONE_Q16 : em_sr[16:0];

	// Emit stage 3: select mode and saturate
	assign em_v = slope_mode ? 17'((em_sq_s3 + 34'd32768) >> 16) : em_s_s3;
	assign em_out.prob        = em_v[16] ? 16'hFFFF : em_v[15:0];
	assign em_out.last_result = em_l_s3;

	always_ff @(posedge clk) begin
		em_l_s1  <= idx_last;
		em_l_s2  <= em_l_s1;
		em_l_s3  <= em_l_s2;
		em_p_s2  <= 42'(em_e_s1) * 42'(recip_q);
		em_s_s3  <= em_s;
		em_sq_s3 <= 34'(em_s) * 34'(ONE_Q16 - em_s);
	end

	// Result queue
	assign oq_push = em_v_s3;
	assign oq_pop  = pop && !empty;
	assign empty   = oq_cnt_q == '0;
	assign result  = oq_q[oq_rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push)
				oq_wr_q <= oq_wr_q + OQ_AW'(1);
			if (oq_pop)
				oq_rd_q <= oq_rd_q + OQ_AW'(1);
			oq_cnt_q <= oq_cnt_q + (OQ_AW + 1)'(oq_push) - (OQ_AW + 1)'(oq_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push)
			oq_q[oq_wr_q] <= em_out;
	end

	a_oq_room: assert property (@(posedge clk) disable iff (!arst_n)
		oq_push |-> (oq_cnt_q < OQ_DEPTH) || oq_pop)
		else $error("result queue overrun");

	a_sum_floor: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> sum_q >= SW'(ONE_Q16))
		else $error("exponent sum below one");

	a_scan_drained: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_EMIT) |-> !sc_v_s1 && !sc_v_s2 && !sc_v_s3)
		else $error("emit started before scan drained");

endmodule

### hdl/softmax_vector_with_slope_core.sv
// Softmax core: loads one score per cycle while full is low; after the last element it
// scans the vector, divides for the reciprocal, then emits one result per cycle while
// the result queue has room. Asynchronous active-low reset clears control, counts,
// maximum and mode; the stores are not cleared.
module softmax_vector_with_slope_core import smx_pkg::*; #(
	parameter int MAX_LEN = SMX_MAX_LEN
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  in_item_t          item,
	output logic              empty,
	input  logic              pop,
	output out_item_t         result,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int AW = $clog2(MAX_LEN);
	localparam int CW = $clog2(MAX_LEN + 1);

	logic               slope_mode_q;
	bk_status_t         status;
	logic [AW-1:0]      rd_addr;
	logic signed [15:0] rd_score;
	logic               job_valid;
	logic [CW-1:0]      job_count;
	logic signed [15:0] job_max;

	// Register transfer
	assign pready = 1'b1;
	assign prdata = 32'(slope_mode_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			slope_mode_q <= 1'b0;
		else if (psel && penable && pwrite && pready && (paddr == REG_SLOPE_MODE))
			slope_mode_q <= pwdata[0];
	end

	smx_front #(.MAX_LEN(MAX_LEN)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.item      (item),
		.status    (status),
		.rd_addr   (rd_addr),
		.rd_score  (rd_score),
		.job_valid (job_valid),
		.job_count (job_count),
		.job_max   (job_max)
	);

	smx_back #(.MAX_LEN(MAX_LEN)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.slope_mode (slope_mode_q),
		.job_valid  (job_valid),
		.job_count  (job_count),
		.job_max    (job_max),
		.status     (status),
		.rd_addr    (rd_addr),
		.rd_score   (rd_score),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule
